>>> hw/rtl/m3inv_pkg.sv
`timescale 1ns / 1ps
package m3inv_pkg;
  localparam int ELEM_W = 16;
  localparam int COF_W = 34;
  localparam int DET_W = 51;
  localparam int NUM_W = COF_W + 24;
  localparam int OUT_W = 32;
  localparam int NUM_ELEM = 9;
  localparam int QBITS = 33;
  localparam int DIV_STAGES = 33;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [OUT_W-1:0] res_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

  localparam res_t Q16_ONE = res_t'(32'sh0001_0000);
  localparam res_t OUT_MAX = res_t'(32'sh7FFF_FFFF);
  localparam res_t OUT_MIN = res_t'(32'sh8000_0000);
endpackage

>>> hw/rtl/m3inv_cof.sv
`timescale 1ns / 1ps
module m3inv_cof (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  m3inv_pkg::elem_t [8:0]          a,
  output logic                            out_valid,
  output m3inv_pkg::cof_t  [8:0]          adj,
  output m3inv_pkg::det_t                 det
);
  import m3inv_pkg::*;

  // stage 1: products of pairs
  logic signed [31:0] p_r [18];
  elem_t              a_r [3];
  logic               v1_r, v2_r, v3_r;
  cof_t               c_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= a[4] * a[8];  p_r[1]  <= a[5] * a[7];
      p_r[2]  <= a[3] * a[8];  p_r[3]  <= a[5] * a[6];
      p_r[4]  <= a[3] * a[7];  p_r[5]  <= a[4] * a[6];
      p_r[6]  <= a[1] * a[8];  p_r[7]  <= a[2] * a[7];
      p_r[8]  <= a[0] * a[8];  p_r[9]  <= a[2] * a[6];
      p_r[10] <= a[0] * a[7];  p_r[11] <= a[1] * a[6];
      p_r[12] <= a[1] * a[5];  p_r[13] <= a[2] * a[4];
      p_r[14] <= a[0] * a[5];  p_r[15] <= a[2] * a[3];
      p_r[16] <= a[0] * a[4];  p_r[17] <= a[1] * a[3];
      a_r[0] <= a[0]; a_r[1] <= a[1]; a_r[2] <= a[2];
      // cofactors c(r,k), stored in row-major order
      c_r[0] <= COF_W'(p_r[0]) - COF_W'(p_r[1]);
      c_r[1] <= COF_W'(p_r[3]) - COF_W'(p_r[2]);
      c_r[2] <= COF_W'(p_r[4]) - COF_W'(p_r[5]);
      c_r[3] <= COF_W'(p_r[7]) - COF_W'(p_r[6]);
      c_r[4] <= COF_W'(p_r[8]) - COF_W'(p_r[9]);
      c_r[5] <= COF_W'(p_r[11]) - COF_W'(p_r[10]);
      c_r[6] <= COF_W'(p_r[12]) - COF_W'(p_r[13]);
      c_r[7] <= COF_W'(p_r[15]) - COF_W'(p_r[14]);
      c_r[8] <= COF_W'(p_r[16]) - COF_W'(p_r[17]);
    end
  end

  // a_r runs one stage ahead of c_r; hold a copy aligned
  elem_t a2_r [3];
  cof_t  c2_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= a_r;
    end
  end

  logic signed [49:0] d0_r, d1_r, d2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= a2_r[0] * c_r[0];
      d1_r <= a2_r[1] * c_r[1];
      d2_r <= a2_r[2] * c_r[2];
      c2_r <= c_r;
    end
  end

  assign out_valid = v3_r;
  assign det = DET_W'(d0_r) + DET_W'(d1_r) + DET_W'(d2_r);
  // adjugate is the transposed cofactor matrix
  assign adj[0] = c2_r[0]; assign adj[1] = c2_r[3]; assign adj[2] = c2_r[6];
  assign adj[3] = c2_r[1]; assign adj[4] = c2_r[4]; assign adj[5] = c2_r[7];
  assign adj[6] = c2_r[2]; assign adj[7] = c2_r[5]; assign adj[8] = c2_r[8];
endmodule

>>> hw/rtl/m3inv_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, all nine lanes share the divisor
module m3inv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  m3inv_pkg::cof_t [8:0]      adj,
  input  m3inv_pkg::det_t            det,
  output logic                       out_valid,
  output logic                       out_singular,
  output m3inv_pkg::res_t [8:0]      b
);
  import m3inv_pkg::*;

  localparam int DV_W = DET_W - 1;   // |det| magnitude
  localparam int NM_W = NUM_W;       // |num| magnitude bits
  localparam int RM_W = DV_W + 1;

  // stage 0: magnitudes and signs
  logic [DV_W-1:0] dv_r [DIV_STAGES+1];
  logic [NM_W-1:0] nm_r [DIV_STAGES+1][9];
  logic [RM_W-1:0] rm_r [DIV_STAGES+1][9];
  logic [QBITS-1:0] q_r [DIV_STAGES+1][9];
  logic            ng_r [DIV_STAGES+1][9];
  ctl_t            ct_r [DIV_STAGES+2];

  logic [DET_W-1:0] dabs;
  assign dabs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STAGES + 1; s++) ct_r[s].valid <= 1'b0;
    end else if (en) begin
      ct_r[0].valid <= in_valid;
      for (int s = 1; s <= DIV_STAGES + 1; s++) ct_r[s].valid <= ct_r[s-1].valid;
    end
    if (en) begin
      ct_r[0].singular <= (det == '0);
      for (int s = 1; s <= DIV_STAGES + 1; s++) ct_r[s].singular <= ct_r[s-1].singular;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dabs[DV_W-1:0];
      for (int i = 0; i < 9; i++) begin
        nm_r[0][i] <= {(adj[i][COF_W-1] ? COF_W'(-adj[i]) : adj[i]), 24'd0};
        ng_r[0][i] <= adj[i][COF_W-1] ^ det[DET_W-1];
        rm_r[0][i] <= '0;
        q_r[0][i]  <= '0;
      end
    end
  end

  // quotient above 2^33 saturates anyway; top numerator bits set a sticky overflow
  logic ov_r [DIV_STAGES+1][9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) ov_r[0][i] <= 1'b0;
    end
  end

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_st
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[s+1] <= dv_r[s];
          for (int i = 0; i < 9; i++) begin
            logic [RM_W:0] t;
            logic [NM_W-1:0] hi;
            t = {rm_r[s][i], 1'b0};
            // bring in numerator bits above the quotient window on the first stage
            if (s == 0) begin
              hi = nm_r[s][i] >> QBITS;
              t = {1'b0, RM_W'(hi)};
            end else begin
              t = {rm_r[s][i], nm_r[s][i][NM_W-1]};
            end
            if (s == 0) begin
              rm_r[s+1][i] <= (t >= {1'b0, dv_r[s]}) ? RM_W'(t - {1'b0, dv_r[s]})
                                                     : RM_W'(t);
              ov_r[s+1][i] <= (t >= {1'b0, dv_r[s]});
              nm_r[s+1][i] <= nm_r[s][i] << (NM_W - QBITS);
              q_r[s+1][i]  <= '0;
            end else begin
              rm_r[s+1][i] <= (t >= {1'b0, dv_r[s]}) ? RM_W'(t - {1'b0, dv_r[s]})
                                                     : RM_W'(t);
              q_r[s+1][i]  <= {q_r[s][i][QBITS-2:0], (t >= {1'b0, dv_r[s]})};
              nm_r[s+1][i] <= nm_r[s][i] << 1;
              ov_r[s+1][i] <= ov_r[s][i];
            end
            ng_r[s+1][i] <= ng_r[s][i];
          end
        end
      end
    end
  endgenerate

  // last stage: the final quotient bit, sign and saturation, or the identity for a singular matrix
  res_t b_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        logic [RM_W:0] t;
        logic [QBITS:0] q;
        logic ov;
        t  = {rm_r[DIV_STAGES][i], nm_r[DIV_STAGES][i][NM_W-1]};
        q  = {q_r[DIV_STAGES][i], (t >= {1'b0, dv_r[DIV_STAGES]})};
        ov = ov_r[DIV_STAGES][i];
        if (ct_r[DIV_STAGES].singular) begin
          b_r[i] <= (i == 0 || i == 4 || i == 8) ? Q16_ONE : '0;
        end else if (ng_r[DIV_STAGES][i]) begin
          b_r[i] <= (ov || q > (QBITS+1)'(33'h0_8000_0000)) ? OUT_MIN
                    : res_t'(-q);
        end else begin
          b_r[i] <= (ov || q > (QBITS+1)'(33'h0_7FFF_FFFF)) ? OUT_MAX : res_t'(q);
        end
      end
    end
  end

  assign out_valid = ct_r[DIV_STAGES+1].valid;
  assign out_singular = ct_r[DIV_STAGES+1].singular;
  always_comb begin
    for (int i = 0; i < 9; i++) b[i] = b_r[i];
  end
endmodule

>>> hw/rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// Pipeline: 3 cofactor/determinant stages, then 35 divider stages including sign setup
// and saturation.
// Throughput: one matrix per cycle; the pipeline stalls as a whole only when the
// output register is full and not taken.
// Reset: rst_n clears the valid bits; data registers are not reset.
module matrix3x3_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // a11,a12,a13,a21,a22,a23,a31,a32,a33 (16b each)
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [287:0]  out_tdata,  // b11..b33 (32b each)
  output logic          out_tuser   // singular
);
  import m3inv_pkg::*;

  logic en;
  elem_t [8:0] a;
  cof_t  [8:0] adj;
  det_t        det;
  logic        cv, dv, ds;
  res_t  [8:0] b;

  // advance the whole pipe unless a valid word waits at the output
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) a[i] = in_tdata[i*ELEM_W +: ELEM_W];
  end

  m3inv_cof u_cof (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .a(a), .out_valid(cv), .adj(adj), .det(det)
  );

  m3inv_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv), .adj(adj), .det(det),
    .out_valid(dv), .out_singular(ds), .b(b)
  );

  assign out_tvalid = dv;
  assign out_tuser = ds;
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) out_tdata[i*OUT_W +: OUT_W] = b[i];
  end
endmodule

>>> verif/m3inv_checker.sv
`timescale 1ns / 1ps
module m3inv_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);
  import m3inv_pkg::*;

  typedef struct {
    logic [287:0] elems;
    logic         singular;
  } inverse_t;

  inverse_t expected_inverses[$];

  function automatic inverse_t invert_matrix(logic [143:0] word);
    longint a[3][3];
    longint cof[3][3];
    longint det;
    longint q;
    inverse_t res;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        a[r][k] = longint'(elem_t'(word[(r*3+k)*ELEM_W +: ELEM_W]));
    cof[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    cof[0][1] = -(a[1][0]*a[2][2] - a[1][2]*a[2][0]);
    cof[0][2] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    cof[1][0] = -(a[0][1]*a[2][2] - a[0][2]*a[2][1]);
    cof[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    cof[1][2] = -(a[0][0]*a[2][1] - a[0][1]*a[2][0]);
    cof[2][0] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    cof[2][1] = -(a[0][0]*a[1][2] - a[0][2]*a[1][0]);
    cof[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    res.elems = '0;
    res.singular = (det == 0);
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        if (det == 0) begin
          q = (r == k) ? longint'(Q16_ONE) : 0;
        end else begin
          // cof * 2^24 fits in 58 bits; SV division truncates toward zero
          q = (cof[k][r] * 64'sd16777216) / det;
          if (q > longint'(OUT_MAX)) q = longint'(OUT_MAX);
          else if (q < longint'(OUT_MIN)) q = longint'(OUT_MIN);
        end
        res.elems[(r*3+k)*OUT_W +: OUT_W] = q[OUT_W-1:0];
      end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_inverses.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[31:0], 0);
        end else begin
          want = expected_inverses.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_tdata[i*OUT_W +: OUT_W] !== want.elems[i*OUT_W +: OUT_W])
              report_mismatch($sformatf("b%0d%0d", i/3+1, i%3+1),
                              out_tdata[i*OUT_W +: OUT_W], want.elems[i*OUT_W +: OUT_W]);
          if (out_tuser !== want.singular)
            report_mismatch("singular", out_tuser, want.singular);
        end
      end
      pending = expected_inverses.size();
    end
  end
endmodule

>>> verif/tb_matrix3x3_inverse.sv
`timescale 1ns / 1ps
module tb_matrix3x3_inverse;
  localparam int LATENCY = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_RANDOM = 1600;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  bit           calm;

  matrix3x3_inverse DUT (.*);

  m3inv_checker u_checker (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  // receiver stalls about 12 percent, except during the calm stretch
  always @(negedge clk)
    out_tready <= calm || ($urandom_range(99) >= 12);

  // count cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      4, 5: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [143:0] random_matrix();
    logic [143:0] m;
    for (int i = 0; i < 9; i++) m[i*16 +: 16] = pick_elem();
    // make some rows dependent to hit a zero determinant
    if ($urandom_range(15) == 0) m[48 +: 16*3] = m[0 +: 48];
    return m;
  endfunction

  task automatic send_matrix(logic [143:0] m, bit gaps);
    while (gaps && $urandom_range(99) < 12) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [143:0] diag(logic [15:0] d1, logic [15:0] d2, logic [15:0] d3);
    return {d3, 48'h0, d2, 48'h0, d1};
  endfunction

  initial begin
    logic [143:0] m;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    calm = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_matrix(diag(16'h0100, 16'h0100, 16'h0100), 1);
    send_matrix(diag(16'h0001, 16'h0001, 16'h0001), 1);
    send_matrix(diag(16'h7FFF, 16'h7FFF, 16'h7FFF), 1);
    send_matrix(diag(16'h8000, 16'h8000, 16'h8000), 1);
    send_matrix(diag(16'h8000, 16'h0001, 16'h0001), 1);
    send_matrix(diag(16'hFFFF, 16'h0001, 16'h7FFF), 1);
    send_matrix('0, 1);
    send_matrix({9{16'h8000}}, 1);
    send_matrix({9{16'h7FFF}}, 1);
    send_matrix({9{16'hFFFF}}, 1);
    send_matrix({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1);
    send_matrix({16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000}, 1);
    send_matrix({16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500,
                 16'h0600, 16'h0700, 16'h0800, 16'h0A00}, 1);
    send_matrix({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 600 && n < 800);
      send_matrix(random_matrix(), !calm);
    end
    calm = 0;
    in_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
